### sv/assert_macros.svh
// Assertion macros shared by the timer pool RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/stp_pkg.sv
// Package for the timer pool: slot record type, codes, sizes.
// No dependencies.
package stp_pkg;
    localparam int SLOTS = 16;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_PAUSE = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    localparam logic [3:0] K_START = 4'd0;
    localparam logic [3:0] K_PAUSE = 4'd1;
    localparam logic [3:0] K_PFOR  = 4'd2;
    localparam logic [3:0] K_RESUME = 4'd3;
    localparam logic [3:0] K_STOP  = 4'd4;
    localparam logic [3:0] K_REFR  = 4'd5;
    localparam logic [3:0] K_RELOAD = 4'd6;
    localparam logic [3:0] K_TICK  = 4'd7;
    localparam logic [3:0] K_RUN   = 4'd8;
    localparam logic [3:0] K_QUERY = 4'd9;

    localparam logic [1:0] R_DONE  = 2'd0;
    localparam logic [1:0] R_START = 2'd1;
    localparam logic [1:0] R_QUERY = 2'd2;
    localparam logic [1:0] R_FIRED = 2'd3;

    localparam int MAX_FIRES = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] countdown;
        logic [31:0] period;
        logic [31:0] delay;
        logic [7:0]  firings;
        logic [7:0]  mode;
        logic [7:0]  prio;
        logic [31:0] id;
    } slot_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] timer_id;
        logic [7:0]  work_count;
        logic [31:0] start_delay;
        logic [31:0] period;
        logic [7:0]  priority_req;
        logic [31:0] amount;
    } cmd_t;

    typedef struct packed {
        logic        last;
        logic        present;
        logic [3:0]  slot_index;
        logic [31:0] answer_id;
        logic [1:0]  result_kind;
    } res_t;
endpackage

### sv/stp_slot_ram.sv
// Slot record memory: one write port, one registered read port.
// Depends on stp_pkg.
module stp_slot_ram
    import stp_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  slot_t         wdata,
    input  logic [SW-1:0] raddr,
    output slot_t         rdata
);
    slot_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/stp_out_buf.sv
// Output register: holds one result word until the master side takes it.
// Depends on stp_pkg.
module stp_out_buf
    import stp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t din,
    output logic full,
    input  logic pop,
    output res_t dout
);
    logic full_reg;
    res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (push)
        begin
            full_reg <= 1'b1;
        end
        else if (pop)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= din;
        end
    end

    assign full = full_reg;
    assign dout = data_reg;
endmodule

### sv/software_timer_pool.sv
// Top level of the timer slot pool: control sequencer around the slot memory.
// Depends on stp_pkg, stp_slot_ram, stp_out_buf, assert_macros.svh.
//
// Usage: command words enter on s_axis (tdata = kind, timer_id, work_count,
// start_delay, period, priority_req, amount). Result words leave on m_axis
// (tdata = result_kind, answer_id, slot_index, present; tlast marks the
// final result of a command).
// The slot records live in a single-port-read memory with a registered read
// port. Every command makes one main sweep over the slots: one read issue
// per cycle while the sweep is not stalled, with each record modified and
// written back when its registered read data arrives.
// A start that finds a free slot then sweeps again to find a fresh id: each
// candidate id costs one sweep, normally one, and the S_WRITE state then
// commits the record. Fired results on neighboring slots stall the sweep
// even with a ready receiver, since the output register is still full.
// A fired result is pushed into the output register and the sweep waits
// (re-reading the same slot) while that register is full, so a stalled
// receiver stalls the sweep with no loss. s_axis_tready is high only when
// the sequencer is idle. After reset the slot memory is cleared by a pass
// (one entry a cycle) before the first command is taken.
`include "assert_macros.svh"
module software_timer_pool
    import stp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[3:0], timer_id[35:4], work_count[43:36], start_delay[75:44],
    // period[107:76], priority_req[115:108], amount[147:116], zero pad
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_kind[1:0], answer_id[33:2], slot_index[37:34], present[38], pad
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;  // main sweep
    localparam logic [2:0] S_IDCHK = 3'd3;  // fresh id sweep
    localparam logic [2:0] S_WRITE = 3'd4;  // commit start
    localparam logic [2:0] S_FIN   = 3'd5;  // final result

    logic [2:0]     state_reg, state_next;
    cmd_t           cmd_reg;
    logic [SCW-1:0] rptr_reg, rptr_next;   // read issue pointer
    logic           rv_reg, rv_next;       // read data valid
    logic [SW-1:0]  rslot_reg, rslot_next; // slot of read data
    logic           found_reg, found_next; // first match / free slot
    logic [SW-1:0]  fslot_reg, fslot_next;
    logic           inuse_reg, inuse_next;
    logic [31:0]    idsrc_reg, idsrc_next;
    logic [31:0]    cand_reg, cand_next;
    logic           pres_reg, pres_next;
    logic [4:0]     fires_reg, fires_next;

    logic          we;
    logic [SW-1:0] waddr, raddr;
    slot_t         wdata, rd, upd;
    logic          push, full;
    res_t          pdata, odata;
    logic          fire_now;
    logic [32:0]   psum;
    logic [31:0]   cand_inc;

    stp_slot_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd)
    );

    stp_out_buf u_out (
        .clk(clk), .rst_n(rst_n), .push(push), .din(pdata), .full(full),
        .pop(m_axis_tready), .dout(odata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = full;
    assign m_axis_tdata  = {1'b0, odata.present, odata.slot_index,
                            odata.answer_id, odata.result_kind};
    assign m_axis_tlast  = odata.last;
    assign cand_inc      = (idsrc_reg + 32'd1 == 32'd0) ? 32'd1 : idsrc_reg + 32'd1;
    assign psum          = {1'b0, rd.countdown} + {1'b0, cmd_reg.amount};

    // per-slot modify of the record just read
    always_comb
    begin
        logic match;
        match    = (rd.status != ST_CLEAR) && (rd.id == cmd_reg.timer_id);
        upd      = rd;
        fire_now = 1'b0;
        unique case (cmd_reg.kind)
            K_PAUSE:
            begin
                if (rd.mode == 8'd0 || rd.status == ST_RUN)
                    upd.status = ST_PAUSE;
            end
            K_PFOR:
            begin
                if (rd.mode == 8'd0 || rd.status == ST_RUN)
                begin
                    upd.countdown = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
                    if (rd.mode == 8'd0)
                        upd.status = ST_RUN;
                end
            end
            K_RESUME:
            begin
                if (rd.status == ST_PAUSE)
                    upd.status = (rd.mode == 8'd0 && rd.prio != 8'd0
                                  && rd.countdown == 32'd0) ? ST_WAIT : ST_RUN;
            end
            K_STOP:
            begin
                if (rd.status == ST_RUN || rd.status == ST_PAUSE)
                    upd = '0;
            end
            K_REFR:
            begin
                if (rd.status == ST_RUN || rd.status == ST_PAUSE)
                    upd.countdown = rd.period;
            end
            K_RELOAD:
            begin
                upd.countdown = cmd_reg.period;
                upd.period    = cmd_reg.period;
            end
            K_TICK:
            begin
                if (rd.status == ST_RUN)
                begin
                    if (rd.delay > cmd_reg.amount)
                        upd.delay = rd.delay - cmd_reg.amount;
                    else if (rd.delay != 32'd0)
                        upd.delay = 32'd0;
                    else if (rd.countdown > cmd_reg.amount)
                        upd.countdown = rd.countdown - cmd_reg.amount;
                    else
                    begin
                        upd.countdown = 32'd0;
                        if (rd.prio == 8'd0)
                            fire_now = 1'b1;
                        else
                            upd.status = ST_WAIT;
                    end
                end
            end
            K_RUN:
            begin
                fire_now = (cmd_reg.priority_req != 8'd0) && (rd.status == ST_WAIT)
                           && (rd.prio == cmd_reg.priority_req);
            end
            default:
            begin
            end
        endcase
        if (fire_now)
        begin
            if (rd.mode == 8'd0 || rd.firings > 8'd1)
            begin
                upd.countdown = rd.period;
                upd.status    = ST_RUN;
                if (rd.mode != 8'd0)
                    upd.firings = rd.firings - 8'd1;
            end
            else
                upd = '0;
        end
        if (!match && cmd_reg.kind != K_TICK && cmd_reg.kind != K_RUN)
            upd = rd;
    end

    always_comb
    begin
        logic  stall, is_match, last_rd;
        slot_t ns;
        state_next = state_reg;
        rptr_next  = rptr_reg;
        rv_next    = rv_reg;
        rslot_next = rslot_reg;
        found_next = found_reg;
        fslot_next = fslot_reg;
        inuse_next = inuse_reg;
        idsrc_next = idsrc_reg;
        cand_next  = cand_reg;
        pres_next  = pres_reg;
        fires_next = fires_reg;
        we    = 1'b0;
        waddr = rslot_reg;
        wdata = upd;
        raddr = rptr_reg[SW-1:0];
        push  = 1'b0;
        pdata = '0;
        is_match = (rd.status != ST_CLEAR) && (rd.id == cmd_reg.timer_id);
        stall    = 1'b0;
        last_rd  = (rslot_reg == SW'(SLOTS - 1));
        ns       = '0;
        unique case (state_reg)
            S_INIT:
            begin
                we        = 1'b1;
                waddr     = rptr_reg[SW-1:0];
                wdata     = '0;
                rptr_next = rptr_reg + SCW'(1);
                if (rptr_reg == SCW'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                rptr_next  = '0;
                rv_next    = 1'b0;
                found_next = 1'b0;
                pres_next  = 1'b0;
                fires_next = '0;
                if (s_axis_tvalid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rv_reg)
                begin
                    if (cmd_reg.kind == K_START)
                    begin
                        if (!found_reg && rd.status == ST_CLEAR)
                        begin
                            found_next = 1'b1;
                            fslot_next = rslot_reg;
                        end
                    end
                    else if (cmd_reg.kind == K_TICK || cmd_reg.kind == K_RUN)
                    begin
                        if (fire_now && fires_reg < 5'(MAX_FIRES))
                        begin
                            if (full)
                                stall = 1'b1;
                            else
                            begin
                                push = 1'b1;
                                pdata.result_kind = R_FIRED;
                                pdata.answer_id   = rd.id;
                                pdata.slot_index  = 4'(rslot_reg);
                                fires_next = fires_reg + 5'd1;
                            end
                        end
                        if (!stall)
                            we = 1'b1;
                    end
                    else if (cmd_reg.kind == K_QUERY)
                    begin
                        if (is_match && cmd_reg.timer_id != 32'd0 && (rd.mode == 8'd0
                            || rd.status == ST_RUN || rd.status == ST_PAUSE))
                            pres_next = 1'b1;
                    end
                    else if (!found_reg && is_match)
                    begin
                        found_next = 1'b1;
                        we = 1'b1;
                    end
                end
                if (!stall)
                begin
                    rv_next    = (rptr_reg < SCW'(SLOTS));
                    rslot_next = rptr_reg[SW-1:0];
                    if (rptr_reg < SCW'(SLOTS))
                        rptr_next = rptr_reg + SCW'(1);
                    if (rv_reg && last_rd)
                    begin
                        rv_next = 1'b0;
                        if (cmd_reg.kind == K_START && (found_next))
                        begin
                            state_next = S_IDCHK;
                            cand_next  = cand_inc;
                            idsrc_next = cand_inc;
                            inuse_next = 1'b0;
                            rptr_next  = '0;
                        end
                        else
                            state_next = S_FIN;
                    end
                end
            end
            S_IDCHK:
            begin
                if (rv_reg && rd.status != ST_CLEAR && rd.id == cand_reg)
                    inuse_next = 1'b1;
                rv_next    = (rptr_reg < SCW'(SLOTS));
                rslot_next = rptr_reg[SW-1:0];
                if (rptr_reg < SCW'(SLOTS))
                    rptr_next = rptr_reg + SCW'(1);
                if (rv_reg && last_rd)
                begin
                    rv_next   = 1'b0;
                    rptr_next = '0;
                    if (inuse_next)
                    begin
                        cand_next  = cand_inc;
                        idsrc_next = cand_inc;
                        inuse_next = 1'b0;
                    end
                    else
                        state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ns.status    = ST_RUN;
                ns.countdown = cmd_reg.period;
                ns.period    = cmd_reg.period;
                ns.delay     = cmd_reg.start_delay;
                ns.firings   = cmd_reg.work_count;
                ns.mode      = cmd_reg.work_count;
                ns.prio      = cmd_reg.priority_req;
                ns.id        = cand_reg;
                we    = 1'b1;
                waddr = fslot_reg;
                wdata = ns;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!full)
                begin
                    push = 1'b1;
                    pdata.last = 1'b1;
                    if (cmd_reg.kind == K_START)
                    begin
                        pdata.result_kind = R_START;
                        if (found_reg)
                        begin
                            pdata.answer_id  = cand_reg;
                            pdata.slot_index = 4'(fslot_reg);
                        end
                    end
                    else if (cmd_reg.kind == K_QUERY)
                    begin
                        pdata.result_kind = R_QUERY;
                        pdata.present     = pres_reg;
                    end
                    else
                        pdata.result_kind = R_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a stalled slot is read again so its record stays in view
        if (stall)
            raddr = rslot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            rptr_reg  <= '0;
            rv_reg    <= 1'b0;
            found_reg <= 1'b0;
            idsrc_reg <= '0;
            fires_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rptr_reg  <= rptr_next;
            rv_reg    <= rv_next;
            found_reg <= found_next;
            idsrc_reg <= idsrc_next;
            fires_reg <= fires_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= cmd_t'({s_axis_tdata[3:0], s_axis_tdata[35:4],
                               s_axis_tdata[43:36], s_axis_tdata[75:44],
                               s_axis_tdata[107:76], s_axis_tdata[115:108],
                               s_axis_tdata[147:116]});
        end
        rslot_reg <= rslot_next;
        fslot_reg <= fslot_next;
        inuse_reg <= inuse_next;
        cand_reg  <= cand_next;
        pres_reg  <= pres_next;
    end

    `ASSERT_IMPL(a_push_free, clk, rst_n, push, !full, "result pushed into full register")
    `ASSERT_IMPL(a_fire_cap, clk, rst_n, 1'b1, fires_reg <= 5'(MAX_FIRES), "fire count overrun")
    `ASSERT_NEXT(a_fin_idle, clk, rst_n, state_reg == S_FIN && !full, state_reg == S_IDLE,
                 "final result did not end command")
endmodule
